@@ rtl/vbmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel brick mirror canonicalizer package
// Shared widths and the per-child result type.
// ----------------------------------------------------------------------------
package vbmc_pkg;

  localparam int unsigned NUM_CHILDREN = 8;
  localparam int unsigned CHILD_W      = 8;
  localparam int unsigned MIRROR_W     = 3;
  localparam int unsigned NUM_MIRRORS  = 8;

  localparam int unsigned OCC_W  = NUM_CHILDREN * CHILD_W;
  localparam int unsigned IDS_W  = NUM_CHILDREN * MIRROR_W;
  localparam int unsigned INV_W  = NUM_CHILDREN * CHILD_W;
  localparam int unsigned OUT_W  = OCC_W + IDS_W + INV_W;

  localparam logic [MIRROR_W-1:0] MIRROR_X = 3'd1;
  localparam logic [MIRROR_W-1:0] MIRROR_Y = 3'd2;
  localparam logic [MIRROR_W-1:0] MIRROR_Z = 3'd4;

  typedef struct packed {
    logic [CHILD_W-1:0]  pattern;
    logic [MIRROR_W-1:0] mirror_id;
    logic [CHILD_W-1:0]  inv_mask;
  } child_res_t;

endpackage : vbmc_pkg
`default_nettype wire

@@ rtl/vbmc_child.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Child canonicalizer
// Mirrors one 2x2x2 byte eight ways, picks the largest pattern with the
// lowest mirror id and builds the invariance mask.
// ----------------------------------------------------------------------------
module vbmc_child
  import vbmc_pkg::*;
(
  input  wire logic [CHILD_W-1:0] child_byte,
  input  wire logic               ext_mode,
  output child_res_t              res
);

  logic [CHILD_W-1:0] mirrored [NUM_MIRRORS];

  always_comb begin
    for (int t = 0; t < NUM_MIRRORS; t++) begin
      for (int i = 0; i < CHILD_W; i++) begin
        mirrored[t][i ^ t] = child_byte[i];
      end
    end
  end

  always_comb begin
    logic [CHILD_W-1:0]  best;
    logic [MIRROR_W-1:0] best_t;
    logic [CHILD_W-1:0]  inv;
    best   = '0;
    best_t = '0;
    inv    = '0;
    for (int t = 0; t < NUM_MIRRORS; t++) begin
      if (mirrored[t] > best) begin
        best   = mirrored[t];
        best_t = MIRROR_W'(t);
      end
    end
    if (ext_mode) begin
      for (int t = 0; t < NUM_MIRRORS; t++) begin
        inv[t] = (mirrored[t] == child_byte);
      end
    end else begin
      inv[0] = (mirrored[MIRROR_X] == child_byte);
      inv[1] = (mirrored[MIRROR_Y] == child_byte);
      inv[2] = (mirrored[MIRROR_Z] == child_byte);
    end
    res.pattern   = best;
    res.mirror_id = best_t;
    res.inv_mask  = inv;
  end

endmodule : vbmc_child
`default_nettype wire

@@ rtl/voxel_brick_mirror_canonicalizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A word accepted into the input register moves to the result register,
// which drives out_tvalid, when that register is empty or out_tready is high.
// Throughput: one word per cycle while out_tready is high; input register,
// child logic, result register, with ready passed back through both stages.
// Reset: rst_n synchronous active low; clears both stage valids and
// extended_mode.
// ----------------------------------------------------------------------------
// Voxel brick mirror canonicalizer
// Canonicalizes the eight 2x2x2 children of a 4x4x4 occupancy brick under
// axis mirrors.
// ----------------------------------------------------------------------------
module voxel_brick_mirror_canonicalizer
  import vbmc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic             cfg_data,      // extended_mode
  input  wire logic             in_tvalid,
  output      logic             in_tready,
  input  wire logic [OCC_W-1:0] in_tdata,      // [63:0] occupancy
  output      logic             out_tvalid,
  input  wire logic             out_tready,
  output      logic [OUT_W-1:0] out_tdata      // [63:0] canonical_patterns,
                                               // [87:64] mirror_ids,
                                               // [151:88] invariance_masks
);

  logic             ext_mode_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic [OCC_W-1:0] s1_occ_r;
  logic             s2_valid_r, s2_valid_nxt;
  logic [OUT_W-1:0] s2_data_r;
  logic [OUT_W-1:0] s2_data_nxt;
  logic             s2_load;
  logic             s1_load;
  child_res_t       child_res [NUM_CHILDREN];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      ext_mode_r <= cfg_data;
    end
  end

  assign s2_load   = s1_valid_r && (!s2_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s2_load;
  assign s1_load   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_valid_r;
    if (s2_load) begin
      s2_valid_nxt = 1'b1;
    end else if (out_tready) begin
      s2_valid_nxt = 1'b0;
    end
  end

  for (genvar k = 0; k < NUM_CHILDREN; k++) begin : g_child
    vbmc_child u_child (
      .child_byte (s1_occ_r[k*CHILD_W +: CHILD_W]),
      .ext_mode   (ext_mode_r),
      .res        (child_res[k])
    );
  end

  always_comb begin
    s2_data_nxt = '0;
    for (int k = 0; k < NUM_CHILDREN; k++) begin
      s2_data_nxt[k*CHILD_W +: CHILD_W]                 = child_res[k].pattern;
      s2_data_nxt[OCC_W + k*MIRROR_W +: MIRROR_W]       = child_res[k].mirror_id;
      s2_data_nxt[OCC_W + IDS_W + k*CHILD_W +: CHILD_W] = child_res[k].inv_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_occ_r <= in_tdata;
    end
    if (s2_load) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = s2_data_r;

endmodule : voxel_brick_mirror_canonicalizer
`default_nettype wire

@@ rtl/vbmc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Canonicalizer port checker
// Watches the top level ports for reset, flow and result sanity.
// ----------------------------------------------------------------------------
module vbmc_checker
  import vbmc_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  a_no_idle_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty result stage");

  a_canon_top_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:0] != 8'h00 |-> out_tdata[7])
    else $error("nonempty canonical pattern lacks top voxel");

  a_empty_child: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:0] == 8'h00 |->
      out_tdata[OCC_W +: MIRROR_W] == '0 &&
      (out_tdata[OCC_W + IDS_W +: CHILD_W] == 8'hFF ||
       out_tdata[OCC_W + IDS_W +: CHILD_W] == 8'h07))
    else $error("empty child result malformed");

endmodule : vbmc_checker

bind voxel_brick_mirror_canonicalizer vbmc_checker u_vbmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel brick mirror canonicalizer testbench
// Streams occupancy bricks through the block in both invariance modes and
// under several idle and stall patterns. Each result word is checked field by
// field against a canonical form computed independently from the same brick.
// ----------------------------------------------------------------------------
module testbench
  import vbmc_pkg::*;
();

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_BRICKS = 75;
  localparam int unsigned NUM_PHASES = 8;

  localparam logic [OCC_W-1:0] CORNER_BRICKS [12] = '{
    64'h0000_0000_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h8040_2010_0804_0201,
    64'h0102_0408_1020_4080,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555,
    64'hCC33_F00F_C33C_9669,
    64'h6996_0FF0_3CC3_AA55,
    64'h0300_C000_0600_1800,
    64'h7F7E_FEFD_FBF7_EFDF,
    64'h0000_00FF_0000_0001,
    64'h8000_0000_0000_0000
  };

  typedef struct packed {
    logic [INV_W-1:0] inv;
    logic [IDS_W-1:0] ids;
    logic [OCC_W-1:0] pats;
  } canon_word_t;

  function automatic logic [CHILD_W-1:0] mirror_child(logic [CHILD_W-1:0] b,
                                                      int unsigned t);
    logic [CHILD_W-1:0] r;
    int unsigned i;
    r = '0;
    for (i = 0; i < CHILD_W; i++) begin
      if (b[i]) r[i ^ t] = 1'b1;
    end
    return r;
  endfunction

  class canon_tracker;
    bit ext_mode;
    canon_word_t expected_q[$];
    int unsigned errors;

    function canon_word_t canonicalize(logic [OCC_W-1:0] occ);
      canon_word_t w;
      logic [CHILD_W-1:0] b, v, best, m;
      logic [MIRROR_W-1:0] best_t;
      int unsigned k, t;
      w = '0;
      for (k = 0; k < NUM_CHILDREN; k++) begin
        b = occ[CHILD_W*k +: CHILD_W];
        best = '0;
        best_t = '0;
        m = '0;
        for (t = 0; t < NUM_MIRRORS; t++) begin
          v = mirror_child(b, t);
          if (v > best) begin
            best = v;
            best_t = t[MIRROR_W-1:0];
          end
          if (v == b) begin
            if (ext_mode) m[t] = 1'b1;
            else if (t == MIRROR_X) m[0] = 1'b1;
            else if (t == MIRROR_Y) m[1] = 1'b1;
            else if (t == MIRROR_Z) m[2] = 1'b1;
          end
        end
        w.pats[CHILD_W*k +: CHILD_W] = best;
        w.ids[MIRROR_W*k +: MIRROR_W] = best_t;
        w.inv[CHILD_W*k +: CHILD_W] = m;
      end
      return w;
    endfunction

    function void note_brick(logic [OCC_W-1:0] occ);
      expected_q = {expected_q, canonicalize(occ)};
    endfunction

    function void check_word(logic [OUT_W-1:0] data);
      canon_word_t got, want;
      got = data;
      if (expected_q.size() == 0) begin
        $error("result word with no brick pending: %h", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.pats !== want.pats) begin
        $error("canonical_patterns: expected %h, got %h", want.pats, got.pats);
        errors++;
      end
      if (got.ids !== want.ids) begin
        $error("mirror_ids: expected %h, got %h", want.ids, got.ids);
        errors++;
      end
      if (got.inv !== want.inv) begin
        $error("invariance_masks: expected %h, got %h", want.inv, got.inv);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OCC_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  canon_tracker tracker;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  voxel_brick_mirror_canonicalizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.ext_mode = cfg_data;
      if (in_tvalid && in_tready) tracker.note_brick(in_tdata);
      if (out_tvalid && out_tready) tracker.check_word(out_tdata);
    end
  end

  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) ||
        (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [OCC_W-1:0] random_brick();
    logic [OCC_W-1:0] occ;
    logic [CHILD_W-1:0] b;
    int unsigned k;
    occ = {$urandom, $urandom};
    if ($urandom_range(3) == 0) return occ;
    for (k = 0; k < NUM_CHILDREN; k++) begin
      b = CHILD_W'($urandom);
      case ($urandom_range(5))
        0: b = '0;
        1: b = '1;
        2: b = b | mirror_child(b, $urandom_range(NUM_MIRRORS - 1));
        3: b = 8'h01 << $urandom_range(CHILD_W - 1);
        default: ;
      endcase
      occ[CHILD_W*k +: CHILD_W] = b;
    end
    return occ;
  endfunction

  task automatic send_brick(logic [OCC_W-1:0] occ);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= occ;
    do @(posedge clk); while (!in_tready);
  endtask

  // hold off input until every pending result has drained
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (tracker.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(bit mode);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned p, n;
    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (CORNER_BRICKS[i]) send_brick(CORNER_BRICKS[i]);
    write_mode(1'b1);
    foreach (CORNER_BRICKS[i]) send_brick(CORNER_BRICKS[i]);

    for (p = 0; p < NUM_PHASES; p++) begin
      write_mode(p[0]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      for (n = 0; n < PHASE_BRICKS; n++) begin
        if (n == PHASE_BRICKS / 2) drain_results();
        send_brick(random_brick());
      end
    end

    idle_pct = 0;
    drain_results();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
